// ===== rtl/core/baro_pkg.sv =====
// Package for the barometric pressure compensation pipeline.
// Holds payload structs, register codes and constants; no dependencies.
package baro_pkg;

	localparam int DIV_W = 32;

	localparam logic [1:0] ST_OK  = 2'd0;
	localparam logic [1:0] ST_DIV = 2'd1;
	localparam logic [1:0] ST_SAT = 2'd2;

	localparam logic [1:0] REG_CAL_FIRST  = 2'd0;
	localparam logic [1:0] REG_CAL_SECOND = 2'd1;
	localparam logic [1:0] REG_CAL_THIRD  = 2'd2;
	localparam logic [1:0] REG_OSS        = 2'd3;

	localparam logic [1:0]  OSS_RESET = 2'd2;
	localparam logic [31:0] B6_OFFSET = 32'd4000;
	localparam logic [31:0] B4_BIAS   = 32'd32768;
	localparam logic [31:0] B7_SCALE  = 32'd50000;
	localparam logic [31:0] C_SQ      = 32'd3038;
	localparam logic [31:0] C_LIN     = 32'hFFFF_E343; // -7357
	localparam logic [31:0] C_OFS     = 32'd3791;
	localparam logic [31:0] PA_MAX    = 32'd262143;

	typedef struct packed {
		logic [15:0] raw_temp;
		logic [23:0] raw_press;
	} baro_in_t;

	typedef struct packed {
		logic [17:0] pressure_pa;
		logic [1:0]  status;
	} baro_out_t;

	// Arithmetic shift right of a 32-bit word.
	function automatic logic [31:0] asr(input logic [31:0] v, input logic [4:0] n);
		asr = 32'($signed(v) >>> n);
	endfunction

	function automatic logic [31:0] sx16(input logic [15:0] v);
		sx16 = {{16{v[15]}}, v};
	endfunction

endpackage

// ===== rtl/core/baro_pressure_compensation.sv =====
// Top level of the barometric pressure compensation pipeline.
// Depends on baro_pkg and baro_div.
//
// Usage: pulse start with in_data (raw temperature and raw pressure). busy is
// always low, so a new beat may enter on every clock. Each beat produces one
// result beat on out_data, marked by done for one cycle; the beat passes
// stages A1..A4, a 32-stage divider for the temperature term, stages B1..B6,
// a second 32-stage divider for the pressure quotient, stages C1..C5, then
// the output register that drives done. Throughput is one beat per cycle; the
// two dividers' bit-per-stage chains set the latency. The receiver cannot stall.
// Calibration is written over the APB port (cal_first at 0x00, cal_second at
// 0x08, cal_third at 0x10, oversampling at 0x18) while no beat is in flight.
// Reset clears all calibration to zero, oversampling to 2, and empties the
// pipeline. status: 0 ok, 1 zero divisor, 2 saturated.
module baro_pressure_compensation import baro_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  baro_in_t    in_data,
	output logic        done,
	output baro_out_t   out_data,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready
);

	logic [63:0] cal_first_q, cal_second_q;
	logic [31:0] cal_third_q;
	logic [1:0]  oss_q;
	logic [1:0]  reg_idx;
	logic        wr_en;

	assign pready  = 1'b1;
	assign busy    = 1'b0;
	assign reg_idx = paddr[4:3];
	assign wr_en   = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_first_q  <= '0;
			cal_second_q <= '0;
			cal_third_q  <= '0;
			oss_q        <= OSS_RESET;
		end else if (wr_en) begin
			case (reg_idx)
				REG_CAL_FIRST:  cal_first_q  <= pwdata;
				REG_CAL_SECOND: cal_second_q <= pwdata;
				REG_CAL_THIRD:  cal_third_q  <= pwdata[31:0];
				REG_OSS:        oss_q        <= pwdata[1:0];
				default:        cal_first_q  <= cal_first_q;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_CAL_FIRST:  prdata = cal_first_q;
			REG_CAL_SECOND: prdata = cal_second_q;
			REG_CAL_THIRD:  prdata = {32'd0, cal_third_q};
			REG_OSS:        prdata = {62'd0, oss_q};
			default:        prdata = '0;
		endcase
	end

	logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
	assign ac1 = sx16(cal_first_q[63:48]);
	assign ac2 = sx16(cal_first_q[47:32]);
	assign ac3 = sx16(cal_first_q[31:16]);
	assign ac4 = {16'd0, cal_first_q[15:0]};
	assign ac5 = {16'd0, cal_second_q[63:48]};
	assign ac6 = {16'd0, cal_second_q[47:32]};
	assign b1  = sx16(cal_second_q[31:16]);
	assign b2  = sx16(cal_second_q[15:0]);
	assign mc  = sx16(cal_third_q[31:16]);
	assign md  = sx16(cal_third_q[15:0]);

	// ---------------- A: temperature front end ----------------
	logic        v_a1, v_a2, v_a3, v_a4;
	logic [31:0] diff_a1, up_a1, up_a2, up_a3, up_a4;
	logic [31:0] x1_a2, x1_a3, num_a3, den_a3;
	logic        ns_a4, zero_a4;
	logic [31:0] x1_a4, ma_a4, mb_a4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_a1, v_a2, v_a3, v_a4} <= '0;
		end else begin
			{v_a1, v_a2, v_a3, v_a4} <= {start, v_a1, v_a2, v_a3};
		end
	end

	always_ff @(posedge clk) begin
		diff_a1 <= {16'd0, in_data.raw_temp} - ac6;
		up_a1   <= {8'd0, in_data.raw_press} >> (4'd8 - {2'd0, oss_q});
		x1_a2   <= asr(diff_a1 * ac5, 5'd15);
		up_a2   <= up_a1;
		x1_a3   <= x1_a2;
		num_a3  <= mc << 11;
		den_a3  <= x1_a2 + md;
		up_a3   <= up_a2;
		x1_a4   <= x1_a3;
		zero_a4 <= den_a3 == '0;
		ns_a4   <= num_a3[31] ^ den_a3[31];
		ma_a4   <= num_a3[31] ? 32'd0 - num_a3 : num_a3;
		mb_a4   <= den_a3[31] ? 32'd0 - den_a3 : den_a3;
		up_a4   <= up_a3;
	end

	localparam int T1_W = 32 + 32 + 2;
	logic            v_d1;
	logic [31:0]     q_d1;
	logic [T1_W-1:0] t_d1;

	baro_div #(.TAG_W(T1_W)) u_div_t (
		.clk(clk), .arst_n(arst_n), .in_valid(v_a4),
		.num(ma_a4), .den(zero_a4 ? 32'd1 : mb_a4),
		.tag_in({x1_a4, up_a4, ns_a4, zero_a4}),
		.out_valid(v_d1), .quo(q_d1), .tag_out(t_d1)
	);

	// ---------------- B: b3, b4, b7 ----------------
	logic [31:0] x1_d1, up_d1;
	logic        ns_d1, zr_d1;
	assign {x1_d1, up_d1, ns_d1, zr_d1} = t_d1;

	logic [5:0]  v_b;
	logic [5:0]  zr_b;
	logic [31:0] b6_b1, up_b1, b6_b2, up_b2, sq_b2, up_b3, up_b4;
	logic [31:0] t1_b3, t2_b3, t3_b3, t4_b3, b3_b4, x3_b4, b3_b5, b4_b5;
	logic [31:0] b7_b6, b4_b6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_b <= '0;
		end else begin
			v_b <= {v_b[4:0], v_d1};
		end
	end

	always_ff @(posedge clk) begin
		zr_b  <= {zr_b[4:0], zr_d1};
		b6_b1 <= x1_d1 + (ns_d1 ? 32'd0 - q_d1 : q_d1) - B6_OFFSET;
		up_b1 <= up_d1;
		b6_b2 <= b6_b1;
		sq_b2 <= asr(b6_b1 * b6_b1, 5'd12);
		up_b2 <= up_b1;
		t1_b3 <= asr(b2 * sq_b2, 5'd11);
		t2_b3 <= asr(ac2 * b6_b2, 5'd11);
		t3_b3 <= asr(ac3 * b6_b2, 5'd13);
		t4_b3 <= asr(b1 * sq_b2, 5'd16);
		up_b3 <= up_b2;
		b3_b4 <= asr((((ac1 << 2) + t1_b3 + t2_b3) << oss_q) + 32'd2, 5'd2);
		x3_b4 <= asr(t3_b3 + t4_b3 + 32'd2, 5'd2);
		up_b4 <= up_b3;
		b3_b5 <= up_b4 - b3_b4;
		b4_b5 <= (ac4 * (x3_b4 + B4_BIAS)) >> 15;
		b7_b6 <= b3_b5 * (B7_SCALE >> oss_q);
		b4_b6 <= b4_b5;
	end

	logic        lo_b6, zb_b6;
	logic [31:0] num2;
	assign lo_b6 = !b7_b6[31];
	assign zb_b6 = zr_b[5] || b4_b6 == '0;
	assign num2  = lo_b6 ? b7_b6 << 1 : b7_b6;

	logic        v_d2;
	logic [31:0] q_d2;
	logic [1:0]  t_d2;

	baro_div #(.TAG_W(2)) u_div_p (
		.clk(clk), .arst_n(arst_n), .in_valid(v_b[5]),
		.num(num2), .den(zb_b6 ? 32'd1 : b4_b6),
		.tag_in({lo_b6, zb_b6}),
		.out_valid(v_d2), .quo(q_d2), .tag_out(t_d2)
	);

	// ---------------- C: second-order correction ----------------
	logic [4:0]  v_c;
	logic [4:0]  z_c;
	logic [31:0] p_c1, p_c2, p_c3, p_c4, sq_c2, x1_c3, x2_c3, p_c5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_c <= '0;
		end else begin
			v_c <= {v_c[3:0], v_d2};
		end
	end

	always_ff @(posedge clk) begin
		z_c   <= {z_c[3:0], t_d2[0]};
		p_c1  <= t_d2[1] ? q_d2 : q_d2 << 1;
		p_c2  <= p_c1;
		sq_c2 <= asr(p_c1, 5'd8) * asr(p_c1, 5'd8);
		p_c3  <= p_c2;
		x1_c3 <= asr(sq_c2 * C_SQ, 5'd16);
		x2_c3 <= asr(C_LIN * p_c2, 5'd16);
		p_c4  <= p_c3 + asr(x1_c3 + x2_c3 + C_OFS, 5'd4);
		p_c5  <= p_c4;
	end

	// p_c5 is a plain delay so the output stage stays register-to-register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= v_c[4];
		end
	end

	always_ff @(posedge clk) begin
		if (z_c[4]) begin
			out_data <= '{pressure_pa: 18'd0, status: ST_DIV};
		end else if (p_c5[31]) begin
			out_data <= '{pressure_pa: 18'd0, status: ST_SAT};
		end else if (p_c5 > PA_MAX) begin
			out_data <= '{pressure_pa: PA_MAX[17:0], status: ST_SAT};
		end else begin
			out_data <= '{pressure_pa: p_c5[17:0], status: ST_OK};
		end
	end

endmodule

// ===== rtl/core/baro_div.sv =====
// Pipelined unsigned 32-bit divider, one quotient bit per stage.
// Carries a tag alongside each operand pair; uses baro_pkg.
module baro_div import baro_pkg::*; #(
	parameter int TAG_W = 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic [DIV_W-1:0] num,
	input  logic [DIV_W-1:0] den,
	input  logic [TAG_W-1:0] tag_in,
	output logic             out_valid,
	output logic [DIV_W-1:0] quo,
	output logic [TAG_W-1:0] tag_out
);

	logic [DIV_W:0]   vld_s;
	logic [DIV_W-1:0] rem_s [DIV_W+1];
	logic [DIV_W-1:0] num_s [DIV_W+1];
	logic [DIV_W-1:0] den_s [DIV_W+1];
	logic [TAG_W-1:0] tag_s [DIV_W+1];

	assign vld_s[0] = in_valid;
	assign rem_s[0] = '0;
	assign num_s[0] = num;
	assign den_s[0] = den;
	assign tag_s[0] = tag_in;

	for (genvar i = 0; i < DIV_W; i++) begin : g_step
		logic [DIV_W:0] trial;
		logic [DIV_W:0] diff;
		assign trial = {rem_s[i], num_s[i][DIV_W-1]};
		assign diff  = trial - {1'b0, den_s[i]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		// Shift the quotient bit into the low end of the numerator word.
		always_ff @(posedge clk) begin
			if (!diff[DIV_W]) begin
				rem_s[i+1] <= diff[DIV_W-1:0];
			end else begin
				rem_s[i+1] <= trial[DIV_W-1:0];
			end
			num_s[i+1] <= {num_s[i][DIV_W-2:0], ~diff[DIV_W]};
			den_s[i+1] <= den_s[i];
			tag_s[i+1] <= tag_s[i];
		end
	end

	assign out_valid = vld_s[DIV_W];
	assign quo       = num_s[DIV_W];
	assign tag_out   = tag_s[DIV_W];

endmodule
